### src/sql_like_matcher_top_macros.svh
// Assertion macros used by the matcher back part.
`ifndef SQL_LIKE_MATCHER_TOP_MACROS_SVH
`define SQL_LIKE_MATCHER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("matcher assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("matcher assertion failed");

`endif

### src/slm_pkg.sv
// Shared constants, types and operation codes of the LIKE pattern matcher.
package slm_pkg;

  localparam int MaxTokens = 32;
  localparam int VecW = MaxTokens + 1;
  localparam int CountW = $clog2(MaxTokens + 1);
  localparam int IdxW = (MaxTokens > 1) ? $clog2(MaxTokens) : 1;

  localparam logic [7:0] EscapeReset = 8'd92;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharUnderscore = 8'h5F;

  localparam int QueueDepth = 2;
  localparam int QPtrW = 1;
  localparam int QCountW = 2;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_PATTERN,
    KIND_STRING,
    KIND_END
  } kind_t;

  typedef enum logic [1:0] {
    TOK_LIT,
    TOK_ONE,
    TOK_RUN
  } tok_kind_t;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_RESTART,
    OP_ADD,
    OP_STEP,
    OP_END
  } op_code_t;

  typedef struct packed {
    op_code_t  op;
    tok_kind_t tok;
    logic [7:0] chr;
    logic      esc;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### src/slm_in_if.sv
// Input channel: item kind and byte with a valid/ready handshake.
interface slm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;

  modport source(output valid, kind, value, input ready);
  modport sink(input valid, kind, value, output ready);
endinterface

### src/slm_out_if.sv
// Result channel: match flag and pattern error with a valid/ready handshake.
interface slm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_error;

  modport source(output valid, matched, pattern_error, input ready);
  modport sink(input valid, matched, pattern_error, output ready);
endinterface

### src/slm_queue.sv
// Two-entry operation queue between the front and back parts.
module slm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  slm_pkg::op_t       din,
  input  logic               pop,
  output slm_pkg::op_t       dout,
  output slm_pkg::q_status_t status
);

  slm_pkg::op_t mem [slm_pkg::QueueDepth];
  logic [slm_pkg::QPtrW-1:0] wr_ptr;
  logic [slm_pkg::QPtrW-1:0] rd_ptr;
  logic [slm_pkg::QCountW-1:0] count;

  assign status.full  = (count == slm_pkg::QCountW'(slm_pkg::QueueDepth));
  assign status.empty = (count == '0);
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/slm_front.sv
// Front part: accepts items, tracks the escape state and emits operations.
module slm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  slm_in_if.sink             item,
  input  slm_pkg::q_status_t q_status,
  output logic               push,
  output slm_pkg::op_t       op
);

  logic [7:0] escape_char;
  logic       escape_pending;
  logic       escape_pending_next;
  slm_pkg::kind_t kind;

  assign item.ready = !q_status.full;
  assign push = item.valid && item.ready;
  assign kind = slm_pkg::kind_t'(item.kind);

  always_comb begin
    op.op = slm_pkg::OP_RESTART;
    op.tok = slm_pkg::TOK_LIT;
    op.chr = item.value;
    op.esc = escape_pending;
    escape_pending_next = escape_pending;
    case (kind)
      slm_pkg::KIND_START: begin
        op.op = slm_pkg::OP_CLEAR;
        escape_pending_next = 1'b0;
      end
      slm_pkg::KIND_PATTERN: begin
        if (escape_pending) begin
          op.op = slm_pkg::OP_ADD;
          escape_pending_next = 1'b0;
        end else if (item.value == escape_char) begin
          op.op = slm_pkg::OP_RESTART;
          escape_pending_next = 1'b1;
        end else if (item.value == slm_pkg::CharPercent) begin
          op.op = slm_pkg::OP_ADD;
          op.tok = slm_pkg::TOK_RUN;
        end else if (item.value == slm_pkg::CharUnderscore) begin
          op.op = slm_pkg::OP_ADD;
          op.tok = slm_pkg::TOK_ONE;
        end else begin
          op.op = slm_pkg::OP_ADD;
        end
      end
      slm_pkg::KIND_STRING: begin
        op.op = slm_pkg::OP_STEP;
      end
      slm_pkg::KIND_END: begin
        op.op = slm_pkg::OP_END;
      end
      default: begin
        op.op = slm_pkg::OP_RESTART;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_char    <= slm_pkg::EscapeReset;
      escape_pending <= 1'b0;
    end else begin
      if (cfg_we) begin
        escape_char <= cfg_wdata;
      end
      if (push) begin
        escape_pending <= escape_pending_next;
      end
    end
  end

endmodule

### src/slm_back.sv
// Back part: token store, active-position vector and result register.
`include "sql_like_matcher_top_macros.svh"

module slm_back (
  input  logic               clk,
  input  logic               rst,
  input  slm_pkg::op_t       op,
  input  slm_pkg::q_status_t q_status,
  output logic               pop,
  slm_out_if.source          res
);

  logic [7:0] tok_chr [slm_pkg::MaxTokens];
  logic [slm_pkg::MaxTokens-1:0] run_v;
  logic [slm_pkg::MaxTokens-1:0] one_v;
  logic [slm_pkg::MaxTokens-1:0] valid_tok;
  logic [slm_pkg::CountW-1:0] token_count;
  logic pattern_overflow;
  logic [slm_pkg::VecW-1:0] active;
  logic out_valid;
  logic out_matched;
  logic out_error;

  logic full_store;
  logic [slm_pkg::IdxW-1:0] wr_idx;
  logic [slm_pkg::VecW-1:0] run_eff;
  logic [slm_pkg::VecW:0] rx;
  logic [slm_pkg::VecW:0] gx;
  logic [slm_pkg::VecW:0] sx;
  logic [slm_pkg::VecW:0] carry;
  logic [slm_pkg::VecW-1:0] cl;
  logic [slm_pkg::VecW-1:0] nx;
  logic err;

  assign pop = !q_status.empty && ((op.op != slm_pkg::OP_END) || !out_valid || res.ready);
  assign full_store = (token_count >= slm_pkg::CountW'(slm_pkg::MaxTokens));
  assign wr_idx = token_count[slm_pkg::IdxW-1:0];

  // Run closure as a carry chain: a run token carries an active position forward.
  assign run_eff = {1'b0, run_v & valid_tok};
  assign rx = {1'b0, run_eff};
  assign gx = rx & {1'b0, active};
  assign sx = rx + gx;
  assign carry = sx ^ rx ^ gx;
  assign cl = active | carry[slm_pkg::VecW-1:0];

  always_comb begin
    nx = '0;
    for (int i = 0; i < slm_pkg::MaxTokens; i++) begin
      nx[i] = nx[i] | (cl[i] & run_eff[i]);
      nx[i+1] = cl[i] & valid_tok[i] & !run_v[i] & (one_v[i] || (tok_chr[i] == op.chr));
    end
  end

  assign err = pattern_overflow || op.esc;

  always_ff @(posedge clk) begin
    if (pop && op.op == slm_pkg::OP_ADD && !full_store) begin
      tok_chr[wr_idx] <= op.chr;
      run_v[wr_idx] <= (op.tok == slm_pkg::TOK_RUN);
      one_v[wr_idx] <= (op.tok == slm_pkg::TOK_ONE);
    end
    if (pop && op.op == slm_pkg::OP_END) begin
      out_matched <= !err && cl[token_count];
      out_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_tok <= '0;
      token_count <= '0;
      pattern_overflow <= 1'b0;
      active <= slm_pkg::VecW'(1);
      out_valid <= 1'b0;
    end else begin
      if (pop && op.op == slm_pkg::OP_END) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        case (op.op)
          slm_pkg::OP_CLEAR: begin
            valid_tok <= '0;
            token_count <= '0;
            pattern_overflow <= 1'b0;
            active <= slm_pkg::VecW'(1);
          end
          slm_pkg::OP_ADD: begin
            if (full_store) begin
              pattern_overflow <= 1'b1;
            end else begin
              valid_tok[wr_idx] <= 1'b1;
              token_count <= token_count + 1'b1;
            end
            active <= slm_pkg::VecW'(1);
          end
          slm_pkg::OP_STEP: begin
            active <= nx;
          end
          default: begin
            active <= slm_pkg::VecW'(1);
          end
        endcase
      end
    end
  end

  assign res.valid = out_valid;
  assign res.matched = out_matched;
  assign res.pattern_error = out_error;

  `SLM_ASSERT_SAME(a_count_bound, 1'b1, token_count <= slm_pkg::CountW'(slm_pkg::MaxTokens))
  `SLM_ASSERT_SAME(a_valid_count, 1'b1, $countones(valid_tok) == int'(token_count))
  `SLM_ASSERT_SAME(a_overflow_full, pattern_overflow, full_store)
  `SLM_ASSERT_NEXT(a_end_restart, pop && op.op == slm_pkg::OP_END, active == slm_pkg::VecW'(1) && out_valid)

endmodule

### src/sql_like_matcher_top.sv
// A result is registered: its end-of-string item passes through the queue, then the result register.
// One item per cycle while the queue has room; the active vector updates every position at once.
// The two-entry queue lets input transfers go on while a result waits to be taken.
// Reset clears the queue, token count, escape state and result register,
// sets the escape byte to 92 and leaves only position zero active; no clearing pass.
module sql_like_matcher_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  slm_in_if.sink     item,
  slm_out_if.source  res
);

  logic               push;
  logic               pop;
  slm_pkg::op_t       front_op;
  slm_pkg::op_t       back_op;
  slm_pkg::q_status_t q_status;

  slm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .q_status  (q_status),
    .push      (push),
    .op        (front_op)
  );

  slm_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (front_op),
    .pop    (pop),
    .dout   (back_op),
    .status (q_status)
  );

  slm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (back_op),
    .q_status (q_status),
    .pop      (pop),
    .res      (res)
  );

endmodule

### tb/sql_like_matcher_top_test.sv
// Self-checking testbench for the LIKE matcher: a directed table, then random phases per escape byte.
module sql_like_matcher_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic matched;
    logic pattern_error;
  } verdict_t;

  localparam verdict_t NONE = 2'b00;
  localparam verdict_t HIT = 2'b10;
  localparam verdict_t MISS = 2'b00;
  localparam verdict_t BAD = 2'b01;
  localparam int StallLimit = 2000;

  typedef struct {
    slm_pkg::kind_t kind;
    logic [7:0]     value;
    int             reps;
    bit             pinned;
    verdict_t       want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  slm_in_if  in_ch ();
  slm_out_if res_ch ();

  sql_like_matcher_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (in_ch),
    .res       (res_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Compiled pattern and NFA state mirrored from the block.
  slm_pkg::tok_kind_t       tok_kind [slm_pkg::MaxTokens];
  logic [7:0]               tok_byte [slm_pkg::MaxTokens];
  int                       tok_count = 0;
  bit                       esc_pending = 1'b0;
  bit                       store_overflow = 1'b0;
  logic [slm_pkg::VecW-1:0] active_pos = slm_pkg::VecW'(1);
  logic [7:0]               esc_byte = slm_pkg::EscapeReset;

  verdict_t pending_verdicts [$];
  int       fail_cnt = 0;
  int       items_sent = 0;
  int       tx_calm = 0;
  int       rx_calm = 0;
  int       rx_wait = 0;
  int       quiet_cycles = 0;

  row_t dir_rows [29] = '{
    '{slm_pkg::KIND_END,     8'h00,                   1,  1'b1, HIT},
    '{slm_pkg::KIND_STRING,  8'hFF,                   1,  1'b0, NONE},
    '{slm_pkg::KIND_END,     8'h00,                   1,  1'b1, MISS},
    '{slm_pkg::KIND_START,   8'hFF,                   1,  1'b0, NONE},
    '{slm_pkg::KIND_PATTERN, slm_pkg::CharPercent,    1,  1'b0, NONE},
    '{slm_pkg::KIND_END,     8'hFF,                   1,  1'b1, HIT},
    '{slm_pkg::KIND_STRING,  8'h00,                   1,  1'b0, NONE},
    '{slm_pkg::KIND_STRING,  8'hFF,                   1,  1'b0, NONE},
    '{slm_pkg::KIND_END,     8'h00,                   1,  1'b1, HIT},
    '{slm_pkg::KIND_START,   8'h00,                   1,  1'b0, NONE},
    '{slm_pkg::KIND_PATTERN, 8'h61,                   1,  1'b0, NONE},
    '{slm_pkg::KIND_PATTERN, slm_pkg::CharUnderscore, 1,  1'b0, NONE},
    '{slm_pkg::KIND_PATTERN, slm_pkg::CharPercent,    1,  1'b0, NONE},
    '{slm_pkg::KIND_PATTERN, slm_pkg::EscapeReset,    1,  1'b0, NONE},
    '{slm_pkg::KIND_PATTERN, slm_pkg::CharPercent,    1,  1'b0, NONE},
    '{slm_pkg::KIND_STRING,  8'h61,                   1,  1'b0, NONE},
    '{slm_pkg::KIND_STRING,  8'hFF,                   1,  1'b0, NONE},
    '{slm_pkg::KIND_STRING,  slm_pkg::CharPercent,    1,  1'b0, NONE},
    '{slm_pkg::KIND_END,     8'h00,                   1,  1'b0, NONE},
    '{slm_pkg::KIND_STRING,  8'h61,                   1,  1'b0, NONE},
    '{slm_pkg::KIND_PATTERN, 8'h00,                   1,  1'b0, NONE},
    '{slm_pkg::KIND_STRING,  8'h61,                   1,  1'b0, NONE},
    '{slm_pkg::KIND_END,     8'h00,                   1,  1'b0, NONE},
    '{slm_pkg::KIND_PATTERN, slm_pkg::EscapeReset,    1,  1'b0, NONE},
    '{slm_pkg::KIND_END,     8'h00,                   1,  1'b1, BAD},
    '{slm_pkg::KIND_START,   8'h00,                   1,  1'b0, NONE},
    '{slm_pkg::KIND_PATTERN, 8'h62,                   33, 1'b0, NONE},
    '{slm_pkg::KIND_STRING,  8'h62,                   1,  1'b0, NONE},
    '{slm_pkg::KIND_END,     8'h00,                   1,  1'b1, BAD}
  };

  function automatic void add_token(input slm_pkg::tok_kind_t kind, input logic [7:0] chr);
    if (tok_count >= slm_pkg::MaxTokens) begin
      store_overflow = 1'b1;
    end else begin
      tok_kind[tok_count] = kind;
      tok_byte[tok_count] = chr;
      tok_count++;
    end
  endfunction

  function automatic void match_step(input slm_pkg::kind_t kind, input logic [7:0] value,
                                     output bit has_res, output verdict_t verdict);
    logic [slm_pkg::VecW-1:0] reach;
    logic [slm_pkg::VecW-1:0] next_pos;
    has_res = 1'b0;
    verdict = NONE;
    case (kind)
      slm_pkg::KIND_START: begin
        tok_count = 0;
        esc_pending = 1'b0;
        store_overflow = 1'b0;
        active_pos = slm_pkg::VecW'(1);
      end
      slm_pkg::KIND_PATTERN: begin
        if (esc_pending) begin
          esc_pending = 1'b0;
          add_token(slm_pkg::TOK_LIT, value);
        end else if (value == esc_byte) begin
          esc_pending = 1'b1;
        end else if (value == slm_pkg::CharPercent) begin
          add_token(slm_pkg::TOK_RUN, 8'h00);
        end else if (value == slm_pkg::CharUnderscore) begin
          add_token(slm_pkg::TOK_ONE, 8'h00);
        end else begin
          add_token(slm_pkg::TOK_LIT, value);
        end
        active_pos = slm_pkg::VecW'(1);
      end
      default: begin
        // A position in front of a run token also reaches the position after it.
        reach = active_pos;
        for (int i = 0; i < tok_count; i++) begin
          if (reach[i] && tok_kind[i] == slm_pkg::TOK_RUN) reach[i+1] = 1'b1;
        end
        if (kind == slm_pkg::KIND_STRING) begin
          next_pos = '0;
          for (int i = 0; i < tok_count; i++) begin
            if (reach[i]) begin
              if (tok_kind[i] == slm_pkg::TOK_RUN) next_pos[i] = 1'b1;
              else if (tok_kind[i] == slm_pkg::TOK_ONE || tok_byte[i] == value)
                next_pos[i+1] = 1'b1;
            end
          end
          active_pos = next_pos;
        end else begin
          has_res = 1'b1;
          verdict.pattern_error = store_overflow || esc_pending;
          verdict.matched = !verdict.pattern_error && reach[tok_count];
          active_pos = slm_pkg::VecW'(1);
        end
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 5))
      0, 1: return 8'h61;
      2: return 8'h62;
      3: return 8'h63;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void note_mismatch(input string what, input int want, input int got);
    if (fail_cnt < 10) $display("mismatch: %s expected %0d got %0d", what, want, got);
    fail_cnt++;
  endfunction

  task automatic send_item(input slm_pkg::kind_t kind, input logic [7:0] value,
                           input bit pinned, input verdict_t pinned_verdict);
    int unsigned gap;
    bit          has_res;
    verdict_t    verdict;
    if (tx_calm != 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 39) == 0) tx_calm = $urandom_range(16, 64);
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    match_step(kind, value, has_res, verdict);
    if (has_res) pending_verdicts.push_back(pinned ? pinned_verdict : verdict);
    items_sent++;
  endtask

  always @(posedge clk) begin
    int unsigned w;
    verdict_t    want;
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_wait <= 0;
    end else if (res_ch.valid && res_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        note_mismatch("unexpected result, matched", 0, res_ch.matched);
      end else begin
        want = pending_verdicts.pop_front();
        if (res_ch.matched !== want.matched)
          note_mismatch("matched", want.matched, res_ch.matched);
        if (res_ch.pattern_error !== want.pattern_error)
          note_mismatch("pattern_error", want.pattern_error, res_ch.pattern_error);
      end
      if (rx_calm != 0) begin
        rx_calm <= rx_calm - 1;
        w = 0;
      end else begin
        w = $urandom_range(0, 8);
        if ($urandom_range(0, 39) == 0) rx_calm <= $urandom_range(16, 64);
      end
      rx_wait <= w;
      res_ch.ready <= (w == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      res_ch.ready <= (rx_wait == 1);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("sql_like_matcher_top_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] esc_plan [6];
    logic [7:0] text [$];
    int         plen;
    int         stop_at;
    esc_plan = '{8'h00, 8'hFF, slm_pkg::CharPercent, slm_pkg::CharUnderscore, 8'h00,
                 slm_pkg::EscapeReset};
    esc_plan[4] = 8'($urandom);
    in_ch.valid <= 1'b0;
    in_ch.kind <= slm_pkg::KIND_START;
    in_ch.value <= 8'h00;
    cfg_we <= 1'b0;
    cfg_wdata <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps)
        send_item(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].pinned, dir_rows[r].want);
    end

    foreach (esc_plan[p]) begin
      // The escape byte may only change once the block has drained.
      in_ch.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= esc_plan[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      esc_byte = esc_plan[p];

      stop_at = items_sent + 250;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 3))
            send_item(slm_pkg::kind_t'($urandom_range(0, 3)), 8'($urandom), 1'b0, NONE);
        end else begin
          send_item(slm_pkg::KIND_START, 8'($urandom), 1'b0, NONE);
          plen = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 7);
          repeat (plen) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3: send_item(slm_pkg::KIND_PATTERN, pick_char(), 1'b0, NONE);
              4, 5: send_item(slm_pkg::KIND_PATTERN, slm_pkg::CharPercent, 1'b0, NONE);
              6: send_item(slm_pkg::KIND_PATTERN, slm_pkg::CharUnderscore, 1'b0, NONE);
              7, 8: begin
                send_item(slm_pkg::KIND_PATTERN, esc_byte, 1'b0, NONE);
                case ($urandom_range(0, 3))
                  0: send_item(slm_pkg::KIND_PATTERN, esc_byte, 1'b0, NONE);
                  1: send_item(slm_pkg::KIND_PATTERN, slm_pkg::CharPercent, 1'b0, NONE);
                  2: send_item(slm_pkg::KIND_PATTERN, slm_pkg::CharUnderscore, 1'b0, NONE);
                  default: send_item(slm_pkg::KIND_PATTERN, pick_char(), 1'b0, NONE);
                endcase
              end
              default: send_item(slm_pkg::KIND_PATTERN, 8'($urandom), 1'b0, NONE);
            endcase
          end
          if ($urandom_range(0, 14) == 0) send_item(slm_pkg::KIND_PATTERN, esc_byte, 1'b0, NONE);

          repeat ($urandom_range(1, 4)) begin
            text.delete();
            if ($urandom_range(0, 2) != 0) begin
              // Build a string that fits the compiled pattern, sometimes with one byte spoiled.
              for (int i = 0; i < tok_count; i++) begin
                case (tok_kind[i])
                  slm_pkg::TOK_LIT: text.push_back(tok_byte[i]);
                  slm_pkg::TOK_ONE: text.push_back(pick_char());
                  default: repeat ($urandom_range(0, 3)) text.push_back(pick_char());
                endcase
              end
              if ($urandom_range(0, 3) == 0 && text.size() != 0)
                text[$urandom_range(0, text.size() - 1)] = pick_char();
            end else begin
              repeat ($urandom_range(0, 8)) text.push_back(pick_char());
            end
            foreach (text[j]) send_item(slm_pkg::KIND_STRING, text[j], 1'b0, NONE);
            send_item(slm_pkg::KIND_END, 8'($urandom), 1'b0, NONE);
          end
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0 && pending_verdicts.size() == 0) begin
      $display("sql_like_matcher_top_test: PASS");
    end else begin
      $display("sql_like_matcher_top_test: FAIL");
    end
    $finish;
  end

endmodule
